// ===== hw/rtl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // Q24 internal fixed point
    localparam int QF        = 24;
    localparam int RAW_W     = 24;
    localparam int SCALE_W   = 23;
    // Dividend is |raw| * 2^25 + k, divisor is 2k
    localparam int WORK_W    = RAW_W + QF + 1;
    localparam int DIV_W     = SCALE_W + 1;
    localparam int DIV_STEPS = WORK_W;
    // Scaled readings stay within 2^47 in magnitude
    localparam int MAG_W     = 48;
    localparam int ACC_W     = 64 + MAG_W;
    // Register stages of one multiply-accumulate cell
    localparam int MAC_LAT   = 7;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] P_MAX   = 64'sd2147483647;
    localparam logic signed [63:0] P_MIN   = -64'sd2147483648;
    localparam logic signed [63:0] T_MAX   = 64'sd8388607;
    localparam logic signed [63:0] T_MIN   = -64'sd8388608;

    typedef enum logic [2:0] {
        CFG_COEF_LO   = 3'd0,
        CFG_COEF_MID  = 3'd1,
        CFG_COEF_HI   = 3'd2,
        CFG_P_SCALE   = 3'd3,
        CFG_T_SCALE   = 3'd4,
        CFG_P_OFFSET  = 3'd5,
        CFG_T_OFFSET  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [23:0] raw_pressure;
        logic signed [23:0] raw_temperature;
    } t_item;

    typedef struct packed {
        logic signed [31:0] pressure_fixed;
        logic signed [23:0] temperature_fixed;
        logic               clipped;
    } t_result;

    // Control travelling alongside a word through the MAC cells
    typedef struct packed {
        logic valid;
        logic sat;
    } t_mac_ctl;

endpackage

// ===== hw/rtl/bsc_div_cell.sv =====
// ----------------------------------------------------------------------------
// bsc_div_cell
// One restoring division step: one quotient bit per cell, per cycle.
// ----------------------------------------------------------------------------
module bsc_div_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             i_neg,
    input  logic [bsc_pkg::DIV_W-1:0]        i_div,
    input  logic [bsc_pkg::DIV_W-1:0]        i_rem,
    input  logic [bsc_pkg::WORK_W-1:0]       i_work,
    output logic                             o_valid,
    output logic                             o_neg,
    output logic [bsc_pkg::DIV_W-1:0]        o_rem,
    output logic [bsc_pkg::WORK_W-1:0]       o_work
);

    logic [bsc_pkg::DIV_W:0]   w_trial;
    logic                      w_ge;
    logic [bsc_pkg::DIV_W:0]   w_diff;
    logic [bsc_pkg::DIV_W-1:0] n_rem;
    logic [bsc_pkg::WORK_W-1:0] n_work;

    // shift the next dividend bit into the remainder, quotient bit in at the bottom
    assign w_trial = {i_rem, i_work[bsc_pkg::WORK_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_div};
    assign w_diff  = w_trial - {1'b0, i_div};
    assign n_rem   = w_ge ? w_diff[bsc_pkg::DIV_W-1:0] : w_trial[bsc_pkg::DIV_W-1:0];
    assign n_work  = {i_work[bsc_pkg::WORK_W-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_neg  <= i_neg;
        o_rem  <= n_rem;
        o_work <= n_work;
    end

endmodule

// ===== hw/rtl/bsc_mac_cell.sv =====
// ----------------------------------------------------------------------------
// bsc_mac_cell
// Saturating c + round(a * b / 2^QF) (or c + a * b), seven register stages;
// four partial products are accumulated over four of those stages.
// ----------------------------------------------------------------------------
module bsc_mac_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bsc_pkg::t_mac_ctl   i_ctl,
    input  logic                i_round,
    input  logic signed [63:0]  i_a,
    input  logic signed [63:0]  i_b,
    input  logic signed [63:0]  i_c,
    output bsc_pkg::t_mac_ctl   o_ctl,
    output logic signed [63:0]  o_res,
    output logic signed [63:0]  o_b
);

    localparam int AW = bsc_pkg::ACC_W;
    localparam int MW = bsc_pkg::MAG_W;

    logic [63:0]        r_ua  [0:3];
    logic [MW-1:0]      r_ub  [0:3];
    logic               r_neg [0:4];
    logic               r_rnd [0:4];
    logic signed [63:0] r_c   [0:5];
    logic signed [63:0] r_b   [0:6];
    bsc_pkg::t_mac_ctl  r_ctl [0:6];
    logic [AW-1:0]      r_acc1, r_acc2, r_acc3, r_acc4;
    logic signed [63:0] r_m;
    logic signed [63:0] r_res;

    logic [63:0]        w_ua, w_ub;
    logic [63:0]        w_pp1, w_pp2;
    logic [47:0]        w_pp3, w_pp4;
    logic [AW-1:0]      w_sum, w_mag;
    logic               w_ovf;
    logic signed [63:0] n_m;
    logic [64:0]        w_add;
    logic               w_add_ovf;
    logic signed [63:0] n_res;

    assign w_ua = i_a[63] ? 64'(-i_a) : 64'(i_a);
    assign w_ub = i_b[63] ? 64'(-i_b) : 64'(i_b);

    assign w_pp1 = r_ua[0][31:0]  * r_ub[0][31:0];
    assign w_pp2 = r_ua[1][63:32] * r_ub[1][31:0];
    assign w_pp3 = r_ua[2][31:0]  * r_ub[2][MW-1:32];
    assign w_pp4 = r_ua[3][63:32] * r_ub[3][MW-1:32];

    // round half away from zero on the magnitude, then check the signed limit
    assign w_sum = r_acc4 + (AW'(1) << (bsc_pkg::QF - 1));
    assign w_mag = r_rnd[4] ? (w_sum >> bsc_pkg::QF) : r_acc4;
    assign w_ovf = (w_mag[AW-1:64] != '0) ||
                   (w_mag[63] && (!r_neg[4] || (w_mag[62:0] != '0)));

    always_comb begin
        if (w_ovf) begin
            n_m = r_neg[4] ? bsc_pkg::S64_MIN : bsc_pkg::S64_MAX;
        end else if (r_neg[4]) begin
            n_m = 64'(-w_mag[63:0]);
        end else begin
            n_m = w_mag[63:0];
        end
    end

    assign w_add     = {r_c[5][63], r_c[5]} + {r_m[63], r_m};
    assign w_add_ovf = w_add[64] != w_add[63];
    assign n_res     = w_add_ovf ? (w_add[64] ? bsc_pkg::S64_MIN : bsc_pkg::S64_MAX)
                                 : w_add[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 7; k++) begin
                r_ctl[k] <= '0;
            end
        end else begin
            r_ctl[0] <= i_ctl;
            for (int k = 1; k < 5; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
            r_ctl[5] <= '{valid: r_ctl[4].valid, sat: r_ctl[4].sat | w_ovf};
            r_ctl[6] <= '{valid: r_ctl[5].valid, sat: r_ctl[5].sat | w_add_ovf};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ua[0]  <= w_ua;
        r_ub[0]  <= w_ub[MW-1:0];
        r_neg[0] <= i_a[63] ^ i_b[63];
        r_rnd[0] <= i_round;
        r_c[0]   <= i_c;
        r_b[0]   <= i_b;
        for (int k = 1; k < 4; k++) begin
            r_ua[k] <= r_ua[k-1];
            r_ub[k] <= r_ub[k-1];
        end
        for (int k = 1; k < 5; k++) begin
            r_neg[k] <= r_neg[k-1];
            r_rnd[k] <= r_rnd[k-1];
        end
        for (int k = 1; k < 6; k++) begin
            r_c[k] <= r_c[k-1];
        end
        for (int k = 1; k < 7; k++) begin
            r_b[k] <= r_b[k-1];
        end
        r_acc1 <= AW'(w_pp1);
        r_acc2 <= r_acc1 + AW'({w_pp2, 32'd0});
        r_acc3 <= r_acc2 + AW'({w_pp3, 32'd0});
        r_acc4 <= r_acc3 + AW'({w_pp4, 64'd0});
        r_m    <= n_m;
        r_res  <= n_res;
    end

    assign o_ctl = r_ctl[6];
    assign o_res = r_res;
    assign o_b   = r_b[6];

endmodule

// ===== hw/rtl/baro_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Pressure / temperature compensation: divider cell rows, then a row of
// multiply-accumulate cells evaluating the calibration polynomials.
//
//   channel   ports                                   direction
//   item      start, busy, i_item                     in, busy out
//   result    o_valid, o_result                       out
//   config    i_cfg_we, i_cfg_idx, i_cfg_data         in
//
// One word enters per cycle while busy is low; each result passes through
// one entry register, 49 divider cells (one quotient bit each), one sign
// register, five MAC cells of seven stages on the pressure path, one output
// register. Reset clears only the valid and sat bits and the configuration
// registers. busy is high only during reset. o_valid is a one-cycle strobe.
// ----------------------------------------------------------------------------
module baro_sensor_compensation #(
    parameter int PRES_FRAC_BITS = 6,
    parameter int TEMP_FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  bsc_pkg::t_item     i_item,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    output logic               o_valid,
    output bsc_pkg::t_result   o_result
);

    localparam int PSH      = bsc_pkg::QF - PRES_FRAC_BITS;
    localparam int TSH      = bsc_pkg::QF - TEMP_FRAC_BITS;
    localparam int NS       = bsc_pkg::DIV_STEPS;
    localparam int TS_DLY   = 4 * bsc_pkg::MAC_LAT;
    localparam int PIPE_LAT = NS + 5 * bsc_pkg::MAC_LAT + 3;

    function automatic logic signed [63:0] round_away(input logic signed [63:0] v,
                                                      input int sh);
        logic [63:0] mag;
        logic [64:0] sum;
        logic [63:0] q;
        mag = v[63] ? 64'(-v) : 64'(v);
        sum = 65'(mag) + (65'(1) << (sh - 1));
        q   = 64'(sum >> sh);
        return v[63] ? 64'(-q) : q;
    endfunction

    // configuration
    logic [63:0]        r_coef_lo, r_coef_mid;
    logic [39:0]        r_coef_hi;
    logic [22:0]        r_p_scale, r_t_scale;
    logic signed [31:0] r_p_off;
    logic signed [23:0] r_t_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_lo  <= '0;
            r_coef_mid <= '0;
            r_coef_hi  <= '0;
            r_p_scale  <= 23'd524288;
            r_t_scale  <= 23'd524288;
            r_p_off    <= '0;
            r_t_off    <= '0;
        end else if (i_cfg_we) begin
            unique case (bsc_pkg::t_cfg_idx'(i_cfg_idx))
                bsc_pkg::CFG_COEF_LO:  r_coef_lo  <= i_cfg_data;
                bsc_pkg::CFG_COEF_MID: r_coef_mid <= i_cfg_data;
                bsc_pkg::CFG_COEF_HI:  r_coef_hi  <= i_cfg_data[39:0];
                bsc_pkg::CFG_P_SCALE:  r_p_scale  <= i_cfg_data[22:0];
                bsc_pkg::CFG_T_SCALE:  r_t_scale  <= i_cfg_data[22:0];
                bsc_pkg::CFG_P_OFFSET: r_p_off    <= i_cfg_data[31:0];
                bsc_pkg::CFG_T_OFFSET: r_t_off    <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // coefficients, sign-extended to 64 bits
    logic signed [63:0] w_c0, w_c1, w_c00, w_c10, w_c01, w_c11;
    logic signed [63:0] w_c20, w_c21, w_c30, w_c31, w_c40;

    assign w_c0  = 64'(signed'(r_coef_lo[63:52]));
    assign w_c1  = 64'(signed'(r_coef_lo[51:40]));
    assign w_c00 = 64'(signed'(r_coef_lo[39:20]));
    assign w_c10 = 64'(signed'(r_coef_lo[19:0]));
    assign w_c01 = 64'(signed'(r_coef_mid[63:48]));
    assign w_c11 = 64'(signed'(r_coef_mid[47:32]));
    assign w_c20 = 64'(signed'(r_coef_mid[31:16]));
    assign w_c21 = 64'(signed'(r_coef_mid[15:0]));
    assign w_c30 = 64'(signed'(r_coef_hi[39:24]));
    assign w_c31 = 64'(signed'(r_coef_hi[23:12]));
    assign w_c40 = 64'(signed'(r_coef_hi[11:0]));

    // entry: build dividend |raw| * 2^25 + k and divisor 2k
    logic [22:0]                 w_p_k, w_t_k;
    logic [bsc_pkg::DIV_W-1:0]   w_p_div, w_t_div;
    logic [23:0]                 w_p_mag, w_t_mag;
    logic                        r_ent_valid, r_ent_pneg, r_ent_tneg;
    logic [bsc_pkg::WORK_W-1:0]  r_ent_pwork, r_ent_twork;

    assign busy    = !i_rst_n;
    assign w_p_k   = (r_p_scale == '0) ? 23'd1 : r_p_scale;
    assign w_t_k   = (r_t_scale == '0) ? 23'd1 : r_t_scale;
    assign w_p_div = {w_p_k, 1'b0};
    assign w_t_div = {w_t_k, 1'b0};
    assign w_p_mag = i_item.raw_pressure[23] ? 24'(-i_item.raw_pressure)
                                             : 24'(i_item.raw_pressure);
    assign w_t_mag = i_item.raw_temperature[23] ? 24'(-i_item.raw_temperature)
                                                : 24'(i_item.raw_temperature);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= 1'b0;
        end else begin
            r_ent_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent_pneg  <= i_item.raw_pressure[23];
        r_ent_tneg  <= i_item.raw_temperature[23];
        r_ent_pwork <= {w_p_mag, 25'd0} + bsc_pkg::WORK_W'(w_p_k);
        r_ent_twork <= {w_t_mag, 25'd0} + bsc_pkg::WORK_W'(w_t_k);
    end

    // divider cell rows
    logic                       w_p_valid [0:NS];
    logic                       w_t_valid [0:NS];
    logic                       w_p_neg   [0:NS];
    logic                       w_t_neg   [0:NS];
    logic [bsc_pkg::DIV_W-1:0]  w_p_rem   [0:NS];
    logic [bsc_pkg::DIV_W-1:0]  w_t_rem   [0:NS];
    logic [bsc_pkg::WORK_W-1:0] w_p_work  [0:NS];
    logic [bsc_pkg::WORK_W-1:0] w_t_work  [0:NS];

    assign w_p_valid[0] = r_ent_valid;
    assign w_t_valid[0] = r_ent_valid;
    assign w_p_neg[0]   = r_ent_pneg;
    assign w_t_neg[0]   = r_ent_tneg;
    assign w_p_rem[0]   = '0;
    assign w_t_rem[0]   = '0;
    assign w_p_work[0]  = r_ent_pwork;
    assign w_t_work[0]  = r_ent_twork;

    for (genvar i = 0; i < NS; i++) begin : g_div
        bsc_div_cell u_p_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_p_valid[i]),
            .i_neg   (w_p_neg[i]),
            .i_div   (w_p_div),
            .i_rem   (w_p_rem[i]),
            .i_work  (w_p_work[i]),
            .o_valid (w_p_valid[i+1]),
            .o_neg   (w_p_neg[i+1]),
            .o_rem   (w_p_rem[i+1]),
            .o_work  (w_p_work[i+1])
        );
        bsc_div_cell u_t_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_t_valid[i]),
            .i_neg   (w_t_neg[i]),
            .i_div   (w_t_div),
            .i_rem   (w_t_rem[i]),
            .i_work  (w_t_work[i]),
            .o_valid (w_t_valid[i+1]),
            .o_neg   (w_t_neg[i+1]),
            .o_rem   (w_t_rem[i+1]),
            .o_work  (w_t_work[i+1])
        );
    end

    // apply sign to the quotients
    logic               r_ps_valid;
    logic signed [63:0] r_ps, r_ts;
    logic [63:0]        w_pq, w_tq;

    assign w_pq = 64'(w_p_work[NS]);
    assign w_tq = 64'(w_t_work[NS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps_valid <= 1'b0;
        end else begin
            r_ps_valid <= w_p_valid[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ps <= w_p_neg[NS] ? 64'(-w_pq) : w_pq;
        r_ts <= w_t_neg[NS] ? 64'(-w_tq) : w_tq;
    end

    // hold ts until the cross term and the temperature cell
    logic signed [63:0] r_ts_dly [0:TS_DLY-1];

    always_ff @(posedge i_clk) begin
        r_ts_dly[0] <= r_ts;
        for (int k = 1; k < TS_DLY; k++) begin
            r_ts_dly[k] <= r_ts_dly[k-1];
        end
    end

    // MAC cell row: pressure Horner chains h and g, cross term, temperature
    bsc_pkg::t_mac_ctl  w_h_ctl [0:3];
    logic signed [63:0] w_h_res [0:3];
    logic signed [63:0] w_h_b   [0:3];
    bsc_pkg::t_mac_ctl  w_g_ctl [0:2];
    logic signed [63:0] w_g_res [0:2];
    logic signed [63:0] w_g_b   [0:2];
    bsc_pkg::t_mac_ctl  w_h_in_ctl [0:3];
    bsc_pkg::t_mac_ctl  w_g_in_ctl [0:2];
    logic signed [63:0] w_h_a [0:3];
    logic signed [63:0] w_h_bi [0:3];
    logic signed [63:0] w_h_c [0:3];
    logic signed [63:0] w_g_a [0:2];
    logic signed [63:0] w_g_bi [0:2];
    logic signed [63:0] w_g_c [0:2];
    bsc_pkg::t_mac_ctl  w_fin_in_ctl, w_fin_ctl, w_tmp_in_ctl, w_tmp_ctl;
    logic signed [63:0] w_fin_res, w_fin_b, w_tmp_res, w_tmp_b;

    assign w_h_in_ctl[0] = '{valid: r_ps_valid, sat: 1'b0};
    assign w_h_a[0]  = w_c40;
    assign w_h_bi[0] = r_ps;
    assign w_h_c[0]  = w_c30 <<< bsc_pkg::QF;
    assign w_h_c[1]  = w_c20 <<< bsc_pkg::QF;
    assign w_h_c[2]  = w_c10 <<< bsc_pkg::QF;
    assign w_h_c[3]  = w_c00 <<< bsc_pkg::QF;

    assign w_g_in_ctl[0] = '{valid: w_h_ctl[0].valid, sat: 1'b0};
    assign w_g_a[0]  = w_c31;
    assign w_g_bi[0] = w_h_b[0];
    assign w_g_c[0]  = w_c21 <<< bsc_pkg::QF;
    assign w_g_c[1]  = w_c11 <<< bsc_pkg::QF;
    assign w_g_c[2]  = w_c01 <<< bsc_pkg::QF;

    for (genvar i = 1; i < 4; i++) begin : g_h_link
        assign w_h_in_ctl[i] = w_h_ctl[i-1];
        assign w_h_a[i]      = w_h_res[i-1];
        assign w_h_bi[i]     = w_h_b[i-1];
    end

    for (genvar i = 1; i < 3; i++) begin : g_g_link
        assign w_g_in_ctl[i] = w_g_ctl[i-1];
        assign w_g_a[i]      = w_g_res[i-1];
        assign w_g_bi[i]     = w_g_b[i-1];
    end

    for (genvar i = 0; i < 4; i++) begin : g_h
        bsc_mac_cell u_h (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_h_in_ctl[i]),
            .i_round (i != 0),
            .i_a     (w_h_a[i]),
            .i_b     (w_h_bi[i]),
            .i_c     (w_h_c[i]),
            .o_ctl   (w_h_ctl[i]),
            .o_res   (w_h_res[i]),
            .o_b     (w_h_b[i])
        );
    end

    for (genvar i = 0; i < 3; i++) begin : g_g
        bsc_mac_cell u_g (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_g_in_ctl[i]),
            .i_round (i != 0),
            .i_a     (w_g_a[i]),
            .i_b     (w_g_bi[i]),
            .i_c     (w_g_c[i]),
            .o_ctl   (w_g_ctl[i]),
            .o_res   (w_g_res[i]),
            .o_b     (w_g_b[i])
        );
    end

    assign w_fin_in_ctl = '{valid: w_h_ctl[3].valid, sat: w_h_ctl[3].sat | w_g_ctl[2].sat};
    assign w_tmp_in_ctl = '{valid: w_h_ctl[3].valid, sat: 1'b0};

    bsc_mac_cell u_fin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_fin_in_ctl),
        .i_round (1'b1),
        .i_a     (w_g_res[2]),
        .i_b     (r_ts_dly[TS_DLY-1]),
        .i_c     (w_h_res[3]),
        .o_ctl   (w_fin_ctl),
        .o_res   (w_fin_res),
        .o_b     (w_fin_b)
    );

    bsc_mac_cell u_tmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_tmp_in_ctl),
        .i_round (1'b0),
        .i_a     (w_c1),
        .i_b     (r_ts_dly[TS_DLY-1]),
        .i_c     (w_c0 <<< (bsc_pkg::QF - 1)),
        .o_ctl   (w_tmp_ctl),
        .o_res   (w_tmp_res),
        .o_b     (w_tmp_b)
    );

    // output: round to output fraction, add offset, clamp
    logic signed [63:0] w_p_sum, w_t_sum;
    logic               w_p_hi, w_p_lo, w_t_hi, w_t_lo;
    logic               r_out_valid;
    bsc_pkg::t_result   r_result;

    assign w_p_sum = round_away(w_fin_res, PSH) + 64'(r_p_off);
    assign w_t_sum = round_away(w_tmp_res, TSH) + 64'(r_t_off);
    assign w_p_hi  = w_p_sum > bsc_pkg::P_MAX;
    assign w_p_lo  = w_p_sum < bsc_pkg::P_MIN;
    assign w_t_hi  = w_t_sum > bsc_pkg::T_MAX;
    assign w_t_lo  = w_t_sum < bsc_pkg::T_MIN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_fin_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.pressure_fixed <= w_p_hi ? 32'(bsc_pkg::P_MAX) :
                                   w_p_lo ? 32'(bsc_pkg::P_MIN) : 32'(w_p_sum);
        r_result.temperature_fixed <= w_t_hi ? 24'(bsc_pkg::T_MAX) :
                                      w_t_lo ? 24'(bsc_pkg::T_MIN) : 24'(w_t_sum);
        r_result.clipped <= w_fin_ctl.sat | w_tmp_ctl.sat |
                            w_p_hi | w_p_lo | w_t_hi | w_t_lo;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    // checks
    a_out_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, PIPE_LAT))
        else $error("result strobe without a start at pipeline depth");

    a_div_rows_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_p_valid[NS] == w_t_valid[NS])
        else $error("divider rows out of step");

    a_chains_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_h_ctl[3].valid == w_g_ctl[2].valid)
        else $error("Horner chains out of step");

    a_tail_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_ctl.valid == w_tmp_ctl.valid)
        else $error("pressure and temperature tails out of step");

endmodule
